// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the checker files.
// No dependencies; every macro clocks on clk and is disabled during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every cycle out of reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/mtg_pkg.sv -----
// Package for the MT19937 generator: word types, request codes and constants.
// No dependencies.
package mtg_pkg;

  localparam int STATE_WORDS_DEF = 624;
  localparam int TWIST_OFFSET    = 397;
  localparam int WARMUP_DRAWS    = 37;
  localparam int WARM_W          = $clog2(WARMUP_DRAWS + 1);

  localparam logic [31:0] MATRIX_A  = 32'h9908_B0DF;
  localparam logic [31:0] SEED_MULT = 32'd1812433253;
  localparam logic [31:0] TEMPER_B  = 32'h9D2C_5680;
  localparam logic [31:0] TEMPER_C  = 32'hEFC6_0000;

  // request codes
  localparam logic REQ_SEED = 1'b0;
  localparam logic REQ_DRAW = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [31:0] seed_value;
  } req_t;

  typedef struct packed {
    logic [31:0] random_word;
    logic        unseeded;
  } rsp_t;

endpackage

// ----- rtl/mtg_twist.sv -----
// Twist and temper datapath: new store word from three store words, and its
// tempered output. Depends on mtg_pkg.
module mtg_twist
  import mtg_pkg::*;
(
  input  logic [31:0] cur_word,
  input  logic [31:0] nxt_word,
  input  logic [31:0] far_word,
  output logic [31:0] twisted,
  output logic [31:0] tempered
);

  logic [31:0] y;
  logic [31:0] t1, t2, t3;

  assign y       = {cur_word[31], nxt_word[30:0]};
  assign twisted = far_word ^ (y >> 1) ^ (y[0] ? MATRIX_A : 32'd0);

  assign t1       = twisted ^ (twisted >> 11);
  assign t2       = t1 ^ ((t1 << 7) & TEMPER_B);
  assign t3       = t2 ^ ((t2 << 15) & TEMPER_C);
  assign tempered = t3 ^ (t3 >> 18);

endmodule

// ----- rtl/mersenne_twister_generator.sv -----
// MT19937 generator, one word twisted per draw, state in a 2-read/1-write store.
// Draw: the accept edge issues the store reads; TWIST then twists, writes back if seeded
//   and registers the result word, waiting while rsp is stalled; no request is taken meanwhile.
// Seed: busy for the store fill and 37 discarded warm-up draws; no result.
// Reset clears control, position and the seeded flag; the store is not cleared.
// A draw before any seed returns zero with unseeded set.
module mersenne_twister_generator
  import mtg_pkg::*;
#(
  parameter int STATE_WORDS = STATE_WORDS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int PW = $clog2(STATE_WORDS);

  // IDLE : takes requests; the store reads for a draw are issued on the accept edge
  // FILL : seed recurrence, one store word per cycle
  // FETCH: wait for the store read data (warm-up draws)
  // TWIST: twist the word at pos, write it back and advance pos (when seeded)
  typedef enum logic [1:0] {IDLE, FILL, FETCH, TWIST} state_t;

  state_t          state;
  logic [PW-1:0]   pos;         // read position
  logic [PW-1:0]   fill_idx;
  logic [PW-1:0]   nxt_pos;
  logic [PW-1:0]   far_pos;
  logic [PW:0]     far_sum;
  logic [WARM_W-1:0] warm;      // warm-up draws still to discard
  logic            seeded;

  // cur always mirrors store[pos], so a draw needs only two reads
  logic [31:0]     cur;
  logic [31:0]     prev;        // last word written during fill
  logic [31:0]     fill_word;
  logic [31:0]     nxt_word;
  logic [31:0]     far_word;
  logic [31:0]     twisted;
  logic [31:0]     tempered;

  logic [31:0]     store [STATE_WORDS];
  logic            wr_en;
  logic [PW-1:0]   wr_addr;
  logic [31:0]     wr_data;

  logic            req_acc;
  logic            rsp_free;
  logic            tw_go;
  logic            rsp_load;

  assign req_stall = (state != IDLE);
  assign req_acc   = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;
  // warm-up draws never wait on the output side
  assign tw_go     = (state == TWIST) && ((warm != '0) || rsp_free);
  // a requested draw hands its word to the output register
  assign rsp_load  = tw_go && (warm == '0);

  // neighbor addresses of pos, modulo STATE_WORDS
  assign nxt_pos = (pos == PW'(STATE_WORDS - 1)) ? '0 : pos + 1'b1;
  assign far_sum = {1'b0, pos} + (PW+1)'(TWIST_OFFSET);
  assign far_pos = (far_sum >= (PW+1)'(STATE_WORDS)) ?
                   PW'(far_sum - (PW+1)'(STATE_WORDS)) : far_sum[PW-1:0];

  assign fill_word = SEED_MULT * (prev ^ (prev >> 30)) + 32'(fill_idx);

  mtg_twist u_twist (
    .cur_word (cur),
    .nxt_word (nxt_word),
    .far_word (far_word),
    .twisted  (twisted),
    .tempered (tempered)
  );

  // single write port: seed word, fill words, twisted words
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos;
    wr_data = twisted;
    case (state)
      IDLE: begin
        if (req_acc && req.req_type == REQ_SEED) begin
          wr_en   = 1'b1;
          wr_addr = '0;
          wr_data = req.seed_value;
        end
      end
      FILL: begin
        wr_en   = 1'b1;
        wr_addr = fill_idx;
        wr_data = fill_word;
      end
      TWIST: begin
        wr_en = tw_go && seeded;
      end
      default: wr_en = 1'b0;
    endcase
  end

  // Reads run every cycle from the current pos. A write at pos lands on the
  // same edge pos advances, so the next read pair already sees it; the only
  // overlap is far == pos at the smallest depth, where the old word is wanted.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
    nxt_word <= store[nxt_pos];
    far_word <= store[far_pos];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      pos       <= '0;
      warm      <= '0;
      seeded    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // output register: load a new word, or drop the one just taken
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (req_acc) begin
            if (req.req_type == REQ_SEED) begin
              prev     <= req.seed_value;
              cur      <= req.seed_value;
              fill_idx <= PW'(1);
              pos      <= '0;
              seeded   <= 1'b1;
              state    <= FILL;
            end else begin
              state <= TWIST;
            end
          end
        end
        FILL: begin
          prev     <= fill_word;
          fill_idx <= fill_idx + 1'b1;
          if (fill_idx == PW'(STATE_WORDS - 1)) begin
            warm  <= WARM_W'(WARMUP_DRAWS);
            state <= FETCH;
          end
        end
        FETCH: begin
          state <= TWIST;
        end
        TWIST: begin
          if (tw_go) begin
            if (seeded) begin
              cur <= nxt_word;
              pos <= nxt_pos;
            end
            if (warm != '0) begin
              warm <= warm - 1'b1;
            end else begin
              rsp.random_word <= seeded ? tempered : 32'd0;
              rsp.unseeded    <= !seeded;
            end
            state <= (warm > WARM_W'(1)) ? FETCH : IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/mtg_checker.sv -----
// Port-level checker for mersenne_twister_generator, bound to the top level.
// Depends on mtg_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mtg_checker
  import mtg_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  logic req_acc;
  logic seen_seed;

  assign req_acc = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_seed <= 1'b0;
    end else if (req_acc && req.req_type == REQ_SEED) begin
      seen_seed <= 1'b1;
    end
  end

  `ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "response changed while stalled")
  `ASSERT_IMPLY(a_unseeded_zero, rsp_valid && rsp.unseeded, rsp.random_word == 32'd0, "unseeded word not zero")
  `ASSERT_IMPLY(a_seeded_word, rsp_valid && !rsp.unseeded, seen_seed, "seeded word before any seed")
  `ASSERT_NEXT(a_busy_after_acc, req_acc, req_stall, "request taken on back-to-back cycles")

endmodule

bind mersenne_twister_generator mtg_checker u_mtg_checker (.*);
